### design/jse_pkg.sv
`default_nettype none

package jse_pkg;

  localparam int COUNTER_WIDTH = 32;
  localparam int COUNT_OUT_W   = 32;
  localparam int BODY_MAX      = 12;
  localparam int OUT_MAX       = 14;
  localparam int OUT_CNT_W     = $clog2(OUT_MAX + 1);
  localparam int BODY_LEN_W    = $clog2(BODY_MAX + 1);
  localparam int POINT_W       = 21;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  localparam logic [POINT_W-1:0] PT_QUOTE  = 21'h22;
  localparam logic [POINT_W-1:0] PT_BSLASH = 21'h5c;
  localparam logic [POINT_W-1:0] PT_BS     = 21'h08;
  localparam logic [POINT_W-1:0] PT_FF     = 21'h0c;
  localparam logic [POINT_W-1:0] PT_LF     = 21'h0a;
  localparam logic [POINT_W-1:0] PT_CR     = 21'h0d;
  localparam logic [POINT_W-1:0] PT_TAB    = 21'h09;
  localparam logic [POINT_W-1:0] PT_SPACE  = 21'h20;
  localparam logic [POINT_W-1:0] PT_ASCII_MAX = 21'h7f;
  localparam logic [POINT_W-1:0] PT_BMP_MAX   = 21'hffff;
  localparam logic [POINT_W-1:0] PT_SUPP_BASE = 21'h10000;

  localparam logic [15:0] HI_SURR   = 16'hd800;
  localparam logic [15:0] LO_SURR   = 16'hdc00;

  localparam logic [COUNTER_WIDTH-1:0] COUNTER_MAX = '1;

  typedef logic [3:0][7:0] seq_t;
  typedef logic [BODY_MAX-1:0][7:0] body_t;

  typedef struct packed {
    logic [OUT_MAX-1:0][7:0] data;
    logic [OUT_CNT_W-1:0]    count;
    logic [COUNT_OUT_W-1:0]  nul_count;
    logic [COUNT_OUT_W-1:0]  non_ascii_count;
  } beat_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) begin
      d = 8'h30 + {4'd0, nib};
    end else begin
      d = 8'h57 + {4'd0, nib};
    end
    return d;
  endfunction

  function automatic logic [5:0][7:0] unicode_escape(input logic [15:0] unit);
    logic [5:0][7:0] e;
    e[0] = CH_BSLASH;
    e[1] = CH_U;
    e[2] = hex_digit(unit[15:12]);
    e[3] = hex_digit(unit[11:8]);
    e[4] = hex_digit(unit[7:4]);
    e[5] = hex_digit(unit[3:0]);
    return e;
  endfunction

  function automatic logic [2:0] lead_length(input logic [7:0] lead);
    logic [2:0] n;
    if (lead < 8'h80) begin
      n = 3'd1;
    end else if (lead < 8'he0) begin
      n = 3'd2;
    end else if (lead < 8'hf0) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

  function automatic logic [COUNT_OUT_W-1:0] count_out(input logic [COUNTER_WIDTH-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return w[COUNT_OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### design/jse_format.sv
`default_nettype none

module jse_format (
  input  wire jse_pkg::seq_t                 seq,
  input  wire logic [2:0]                    seq_len,
  input  wire logic                          escape_wide,
  output jse_pkg::body_t                     body,
  output logic [jse_pkg::BODY_LEN_W-1:0]     body_len,
  output logic                               nul_hit,
  output logic                               non_ascii_hit
);

  logic [jse_pkg::POINT_W-1:0] point;
  logic [jse_pkg::POINT_W-1:0] supp;
  logic [15:0]                 hi_unit;
  logic [15:0]                 lo_unit;
  logic                        short_hit;
  logic [7:0]                  short_char;

  always_comb begin
    unique case (seq_len)
      3'd2: point = {10'd0, seq[0][4:0], seq[1][5:0]};
      3'd3: point = {5'd0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
      3'd4: point = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
      default: point = {13'd0, seq[0]};
    endcase
  end

  assign supp    = point - jse_pkg::PT_SUPP_BASE;
  assign hi_unit = jse_pkg::HI_SURR + {5'd0, supp[20:10]};
  assign lo_unit = jse_pkg::LO_SURR + {6'd0, supp[9:0]};

  always_comb begin
    short_hit  = 1'b1;
    short_char = jse_pkg::CH_QUOTE;
    unique case (point)
      jse_pkg::PT_QUOTE:  short_char = jse_pkg::CH_QUOTE;
      jse_pkg::PT_BSLASH: short_char = jse_pkg::CH_BSLASH;
      jse_pkg::PT_BS:     short_char = jse_pkg::CH_B;
      jse_pkg::PT_FF:     short_char = jse_pkg::CH_F;
      jse_pkg::PT_LF:     short_char = jse_pkg::CH_N;
      jse_pkg::PT_CR:     short_char = jse_pkg::CH_R;
      jse_pkg::PT_TAB:    short_char = jse_pkg::CH_T;
      default:            short_hit  = 1'b0;
    endcase
  end

  always_comb begin
    body          = '0;
    body_len      = '0;
    nul_hit       = 1'b0;
    non_ascii_hit = 1'b0;
    if (short_hit) begin
      body[0]  = jse_pkg::CH_BSLASH;
      body[1]  = short_char;
      body_len = jse_pkg::BODY_LEN_W'(2);
    end else if (point < jse_pkg::PT_SPACE) begin
      body[5:0] = jse_pkg::unicode_escape(point[15:0]);
      body_len  = jse_pkg::BODY_LEN_W'(6);
      nul_hit   = (point == '0);
    end else if (escape_wide && point > jse_pkg::PT_ASCII_MAX) begin
      non_ascii_hit = 1'b1;
      if (point <= jse_pkg::PT_BMP_MAX) begin
        body[5:0] = jse_pkg::unicode_escape(point[15:0]);
        body_len  = jse_pkg::BODY_LEN_W'(6);
      end else begin
        body[5:0]  = jse_pkg::unicode_escape(hi_unit);
        body[11:6] = jse_pkg::unicode_escape(lo_unit);
        body_len   = jse_pkg::BODY_LEN_W'(12);
      end
    end else begin
      body[3:0] = seq;
      body_len  = jse_pkg::BODY_LEN_W'(seq_len);
    end
  end

endmodule

`default_nettype wire

### design/jse_front.sv
`default_nettype none

module jse_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_byte_valid,
  input  wire logic          in_open_quote,
  input  wire logic          in_close_quote,
  input  wire logic          cfg_wr_en,
  input  wire logic          cfg_wr_data,
  input  wire logic          emit_free,
  output logic               emit_load,
  output jse_pkg::beat_t     emit_beat
);

  // input register
  logic       a_valid;
  logic [7:0] a_byte;
  logic       a_bv;
  logic       a_oq;
  logic       a_cq;

  logic escape_wide;

  // sequence gathering state
  logic [2:0][7:0] pend;
  logic [1:0]      pend_len;
  logic [2:0]      seq_len;
  logic [jse_pkg::COUNTER_WIDTH-1:0] nul_cnt;
  logic [jse_pkg::COUNTER_WIDTH-1:0] non_ascii_cnt;

  logic [2:0][7:0] pend_next;
  logic [1:0]      pend_len_next;
  logic [2:0]      seq_len_next;
  logic [jse_pkg::COUNTER_WIDTH-1:0] nul_cnt_next;
  logic [jse_pkg::COUNTER_WIDTH-1:0] non_ascii_cnt_next;

  logic [1:0]      pl;
  logic [2:0]      sl;
  logic [2:0]      lead_n;
  logic            emit;
  jse_pkg::seq_t   seq;
  logic [2:0]      emit_len;

  jse_pkg::body_t                  body;
  logic [jse_pkg::BODY_LEN_W-1:0]  body_len;
  logic [jse_pkg::BODY_LEN_W-1:0]  body_len_eff;
  logic                            nul_hit;
  logic                            non_ascii_hit;
  logic [jse_pkg::OUT_CNT_W-1:0]   total;
  logic [jse_pkg::OUT_CNT_W-1:0]   close_pos;
  logic                            fire;

  assign in_ready = !a_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      a_valid <= 1'b1;
    end else if (fire) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_byte <= in_byte;
      a_bv   <= in_byte_valid;
      a_oq   <= in_open_quote;
      a_cq   <= in_close_quote;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_wide <= 1'b0;
    end else if (cfg_wr_en) begin
      escape_wide <= cfg_wr_data;
    end
  end

  assign lead_n = jse_pkg::lead_length(a_byte);

  always_comb begin
    sl            = a_oq ? 3'd0 : seq_len;
    pl            = a_oq ? 2'd0 : pend_len;
    pend_next     = pend;
    pend_len_next = pl;
    seq_len_next  = sl;
    emit          = 1'b0;
    emit_len      = 3'd1;
    seq           = {4{a_byte}};
    if (a_bv) begin
      if (sl == 3'd0) begin
        if (lead_n == 3'd1) begin
          emit = 1'b1;
        end else begin
          pend_next[0]  = a_byte;
          pend_len_next = 2'd1;
          seq_len_next  = lead_n;
        end
      end else if (({1'b0, pl} + 3'd1) < sl) begin
        pend_next[pl] = a_byte;
        pend_len_next = pl + 2'd1;
      end else begin
        emit          = 1'b1;
        emit_len      = {1'b0, pl} + 3'd1;
        seq[0]        = pend[0];
        seq[1]        = (pl == 2'd1) ? a_byte : pend[1];
        seq[2]        = (pl == 2'd2) ? a_byte : pend[2];
        seq[3]        = a_byte;
        pend_len_next = 2'd0;
        seq_len_next  = 3'd0;
      end
    end
    if (a_cq) begin
      pend_len_next = 2'd0;
      seq_len_next  = 3'd0;
    end
  end

  jse_format u_format (
    .seq              (seq),
    .seq_len          (emit_len),
    .escape_wide      (escape_wide),
    .body             (body),
    .body_len         (body_len),
    .nul_hit          (nul_hit),
    .non_ascii_hit    (non_ascii_hit)
  );

  assign body_len_eff = emit ? body_len : '0;

  always_comb begin
    nul_cnt_next       = nul_cnt;
    non_ascii_cnt_next = non_ascii_cnt;
    if (emit && nul_hit && nul_cnt != jse_pkg::COUNTER_MAX) begin
      nul_cnt_next = nul_cnt + 1'b1;
    end
    if (emit && non_ascii_hit && non_ascii_cnt != jse_pkg::COUNTER_MAX) begin
      non_ascii_cnt_next = non_ascii_cnt + 1'b1;
    end
  end

  assign close_pos = jse_pkg::OUT_CNT_W'(a_oq) + jse_pkg::OUT_CNT_W'(body_len_eff);
  assign total     = close_pos + jse_pkg::OUT_CNT_W'(a_cq);

  always_comb begin
    emit_beat.count           = total;
    emit_beat.nul_count       = jse_pkg::count_out(nul_cnt_next);
    emit_beat.non_ascii_count = jse_pkg::count_out(non_ascii_cnt_next);
    for (int i = 0; i < jse_pkg::OUT_MAX; i++) begin
      emit_beat.data[i] = jse_pkg::CH_QUOTE;
      if (a_oq) begin
        if (i >= 1 && i <= jse_pkg::BODY_MAX) begin
          if (jse_pkg::OUT_CNT_W'(i) < close_pos) begin
            emit_beat.data[i] = body[i-1];
          end
        end
      end else if (i < jse_pkg::BODY_MAX) begin
        if (jse_pkg::OUT_CNT_W'(i) < close_pos) begin
          emit_beat.data[i] = body[i];
        end
      end
    end
  end

  assign fire      = a_valid && ((total == '0) || emit_free);
  assign emit_load = fire && (total != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_len      <= 2'd0;
      seq_len       <= 3'd0;
      nul_cnt       <= '0;
      non_ascii_cnt <= '0;
    end else if (fire) begin
      pend_len      <= pend_len_next;
      seq_len       <= seq_len_next;
      nul_cnt       <= nul_cnt_next;
      non_ascii_cnt <= non_ascii_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pend <= pend_next;
    end
  end

endmodule

`default_nettype wire

### design/jse_emit.sv
`default_nettype none

module jse_emit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  wire jse_pkg::beat_t beat_in,
  output logic                free,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic [jse_pkg::COUNT_OUT_W-1:0] out_nul_count,
  output logic [jse_pkg::COUNT_OUT_W-1:0] out_non_ascii_count
);

  jse_pkg::beat_t                beat;
  logic                          valid;
  logic [jse_pkg::OUT_CNT_W-1:0] idx;

  assign out_valid           = valid;
  assign out_byte            = beat.data[idx];
  assign out_last            = (idx == beat.count - 1'b1);
  assign out_nul_count       = beat.nul_count;
  assign out_non_ascii_count = beat.non_ascii_count;
  assign free                = !valid || (out_ready && out_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (valid && out_ready) begin
      if (out_last) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat <= beat_in;
    end
  end

endmodule

`default_nettype wire

### design/json_string_escaper.sv
// json string escaper
// input stream carries one string byte per beat: tdata is the byte, tuser holds
// byte_valid, open_quote and close_quote from bit 0 up. open_quote puts a quote
// before the byte, close_quote one after it; byte_valid low with both quotes
// set gives an empty string. multibyte utf-8 sequences are gathered and spelled
// as json text once their last byte arrives.
// output stream carries one json byte per beat with tlast on the last byte that
// an input beat caused, plus the saturating nul and non-ascii escape counts.
// cfg_wr_en / cfg_wr_data write the non-ascii escape mode bit.
// an input beat passes the input register, then the result register, before its
// first output byte. one input beat per cycle while each beat makes at most one
// output byte and the receiver is ready; a beat making several bytes holds the
// result register until its last byte is taken, so the single output byte port
// sets the rate. beats that only gather a byte leave with no output, unheld.
// a stalled receiver holds the result register, then the input register, and
// then s_axis_tready drops. reset empties both registers, clears the gathered
// sequence, both counters and the mode bit.

`default_nettype none

module json_string_escaper (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic [2:0]  s_axis_tuser,   // byte_valid, open_quote, close_quote
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // out_byte, nul_escape_count, non_ascii_escape_count
  output logic             m_axis_tlast,   // last_of_run
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data     // non-ascii escape mode
);

  logic           emit_free;
  logic           emit_load;
  jse_pkg::beat_t emit_beat;
  logic [7:0]     out_byte;
  logic [jse_pkg::COUNT_OUT_W-1:0] nul_count;
  logic [jse_pkg::COUNT_OUT_W-1:0] non_ascii_count;

  jse_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .in_byte        (s_axis_tdata),
    .in_byte_valid  (s_axis_tuser[0]),
    .in_open_quote  (s_axis_tuser[1]),
    .in_close_quote (s_axis_tuser[2]),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .emit_free      (emit_free),
    .emit_load      (emit_load),
    .emit_beat      (emit_beat)
  );

  jse_emit u_emit (
    .clk                 (clk),
    .rst                 (rst),
    .load                (emit_load),
    .beat_in             (emit_beat),
    .free                (emit_free),
    .out_valid           (m_axis_tvalid),
    .out_ready           (m_axis_tready),
    .out_byte            (out_byte),
    .out_last            (m_axis_tlast),
    .out_nul_count       (nul_count),
    .out_non_ascii_count (non_ascii_count)
  );

  assign m_axis_tdata = {non_ascii_count, nul_count, out_byte};

  // a run never pauses once started: buffered bytes follow at once
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("output run broken before tlast");

  // counts are fixed for all bytes of one run
  a_counts_per_run: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tdata[71:8] == $past(m_axis_tdata[71:8]))
    else $error("escape counts changed inside a run");

  // the nul count never goes down between beats
  a_nul_monotonic: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready |=>
      !m_axis_tvalid || m_axis_tdata[39:8] >= $past(m_axis_tdata[39:8]))
    else $error("nul escape count decreased");

  // a loaded beat never overwrites an unfinished run
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit_load |-> !m_axis_tvalid || (m_axis_tready && m_axis_tlast))
    else $error("result register loaded while busy");

endmodule

`default_nettype wire

### tb/json_string_escaper_tb.sv
`timescale 1ns / 1ps

module json_string_escaper_tb;

  typedef struct packed {
    logic        last;
    logic [31:0] non_ascii;
    logic [31:0] nul;
    logic [7:0]  ch;
  } json_beat_t;

  typedef struct {
    logic [7:0] data;
    bit         valid;
    bit         oq;
    bit         cq;
  } str_item_t;

  class json_scoreboard;
    bit          escape_wide;
    logic [7:0]  held[3];
    int          held_len;
    int          seq_len;
    logic [31:0] nul_cnt;
    logic [31:0] non_ascii_cnt;
    logic [7:0]  step_bytes[$];
    json_beat_t  expected[$];
    int          errors;
    string       hex_chars = "0123456789abcdef";

    function new();
      escape_wide = 0;
      held_len = 0;
      seq_len = 0;
      nul_cnt = '0;
      non_ascii_cnt = '0;
      errors = 0;
    endfunction

    function void set_mode(bit v);
      escape_wide = v;
    endfunction

    function void put_pair(logic [7:0] letter);
      step_bytes.push_back(jse_pkg::CH_BSLASH);
      step_bytes.push_back(letter);
    endfunction

    function void put_unit(logic [15:0] unit);
      step_bytes.push_back(jse_pkg::CH_BSLASH);
      step_bytes.push_back(jse_pkg::CH_U);
      for (int i = 3; i >= 0; i--) begin
        step_bytes.push_back(hex_chars[unit[i*4 +: 4]]);
      end
    endfunction

    function void spell_point(jse_pkg::seq_t seq, int n);
      logic [20:0] p;
      logic [20:0] s;
      case (n)
        1: p = {13'd0, seq[0]};
        2: p = {10'd0, seq[0][4:0], seq[1][5:0]};
        3: p = {5'd0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
        default: p = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
      endcase
      case (p)
        jse_pkg::PT_QUOTE:  put_pair(jse_pkg::CH_QUOTE);
        jse_pkg::PT_BSLASH: put_pair(jse_pkg::CH_BSLASH);
        jse_pkg::PT_BS:     put_pair(jse_pkg::CH_B);
        jse_pkg::PT_FF:     put_pair(jse_pkg::CH_F);
        jse_pkg::PT_LF:     put_pair(jse_pkg::CH_N);
        jse_pkg::PT_CR:     put_pair(jse_pkg::CH_R);
        jse_pkg::PT_TAB:    put_pair(jse_pkg::CH_T);
        default: begin
          if (p < jse_pkg::PT_SPACE) begin
            put_unit(p[15:0]);
            if (p == 0 && nul_cnt != '1) nul_cnt++;
          end else if (escape_wide && p > jse_pkg::PT_ASCII_MAX) begin
            if (p <= jse_pkg::PT_BMP_MAX) begin
              put_unit(p[15:0]);
            end else begin
              s = p - jse_pkg::PT_SUPP_BASE;
              put_unit(jse_pkg::HI_SURR + 16'(s >> 10));
              put_unit(jse_pkg::LO_SURR + {6'd0, s[9:0]});
            end
            if (non_ascii_cnt != '1) non_ascii_cnt++;
          end else begin
            for (int i = 0; i < n; i++) step_bytes.push_back(seq[i]);
          end
        end
      endcase
    endfunction

    function void note_input(logic [7:0] b, bit valid, bit oq, bit cq);
      jse_pkg::seq_t seq;
      int            n;
      json_beat_t    beat;
      step_bytes.delete();
      if (oq) begin
        step_bytes.push_back(jse_pkg::CH_QUOTE);
        held_len = 0;
        seq_len = 0;
      end
      if (valid) begin
        if (seq_len == 0) begin
          n = (b < 8'h80) ? 1 : (b < 8'he0) ? 2 : (b < 8'hf0) ? 3 : 4;
          if (n == 1) begin
            seq = '0;
            seq[0] = b;
            spell_point(seq, 1);
          end else begin
            held[0] = b;
            held_len = 1;
            seq_len = n;
          end
        end else if (held_len + 1 < seq_len) begin
          held[held_len] = b;
          held_len++;
        end else begin
          seq = '0;
          for (int k = 0; k < held_len; k++) seq[k] = held[k];
          seq[held_len] = b;
          spell_point(seq, held_len + 1);
          held_len = 0;
          seq_len = 0;
        end
      end
      if (cq) begin
        step_bytes.push_back(jse_pkg::CH_QUOTE);
        held_len = 0;
        seq_len = 0;
      end
      foreach (step_bytes[k]) begin
        beat.ch = step_bytes[k];
        beat.last = (k == step_bytes.size() - 1);
        beat.nul = nul_cnt;
        beat.non_ascii = non_ascii_cnt;
        expected.push_back(beat);
      end
    endfunction

    function void check_result(logic [71:0] data, logic last);
      json_beat_t got;
      json_beat_t want;
      got = {last, data};
      if (expected.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual byte %h last %b",
                 $time, got.ch, got.last);
        errors++;
      end else begin
        want = expected.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch, expected byte %h last %b nul %0d non_ascii %0d",
                   $time, want.ch, want.last, want.nul, want.non_ascii);
          $display("%0t:           actual   byte %h last %b nul %0d non_ascii %0d",
                   $time, got.ch, got.last, got.nul, got.non_ascii);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;

  json_scoreboard sb = new();
  str_item_t      stim[$];
  int             live_items = 0;
  bit             long_hold_req = 0;

  json_string_escaper i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always #2 clk = ~clk;

  function automatic void add_item(logic [7:0] data, bit valid, bit oq, bit cq);
    str_item_t it;
    it.data = data;
    it.valid = valid;
    it.oq = oq;
    it.cq = cq;
    stim.push_back(it);
    if (valid || oq || cq) live_items++;
  endfunction

  // utf-8 style encoding on nb bytes, overlong when nb is larger than needed
  function automatic void add_point(logic [20:0] p, int nb, int used, bit oq, bit cq);
    logic [7:0] enc[4];
    case (nb)
      1: enc[0] = p[7:0];
      2: begin
        enc[0] = {3'b110, p[10:6]};
        enc[1] = {2'b10, p[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, p[15:12]};
        enc[1] = {2'b10, p[11:6]};
        enc[2] = {2'b10, p[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, p[20:18]};
        enc[1] = {2'b10, p[17:12]};
        enc[2] = {2'b10, p[11:6]};
        enc[3] = {2'b10, p[5:0]};
      end
    endcase
    for (int i = 0; i < used; i++) begin
      add_item(enc[i], 1, oq && i == 0, cq && i == used - 1);
    end
  endfunction

  function automatic void add_directed();
    add_item(8'h00, 0, 1, 1);                   // empty string
    add_point(jse_pkg::PT_QUOTE, 1, 1, 1, 0);
    add_point(jse_pkg::PT_BSLASH, 1, 1, 0, 0);
    add_point(jse_pkg::PT_BS, 1, 1, 0, 0);
    add_point(jse_pkg::PT_FF, 1, 1, 0, 0);
    add_point(jse_pkg::PT_LF, 1, 1, 0, 0);
    add_point(jse_pkg::PT_CR, 1, 1, 0, 0);
    add_point(jse_pkg::PT_TAB, 1, 1, 0, 0);
    add_point(21'h0, 1, 1, 0, 0);
    add_point(21'h1f, 1, 1, 0, 0);
    add_point(jse_pkg::PT_SPACE, 1, 1, 0, 0);
    add_point(jse_pkg::PT_ASCII_MAX, 1, 1, 0, 0);
    add_point(21'h0, 2, 2, 0, 0);               // overlong nul
    add_point(21'h41, 2, 2, 0, 0);              // overlong printable
    add_point(21'he9, 2, 2, 0, 0);
    add_point(21'h20ac, 3, 3, 0, 0);
    add_point(jse_pkg::PT_BMP_MAX, 3, 3, 0, 0);
    add_point(21'h1f600, 4, 4, 0, 1);
    // stray continuation acts as a two byte lead
    add_item(8'h80, 1, 1, 0);
    add_item(8'hbf, 1, 0, 0);
    // all-ones lead and continuations
    repeat (4) add_item(8'hff, 1, 0, 0);
    // no byte in the middle of a sequence keeps it
    add_item(8'he2, 1, 0, 0);
    add_item(8'h00, 0, 0, 0);
    add_item(8'h82, 1, 0, 0);
    add_item(8'hac, 1, 0, 1);
    // open quote drops the partial sequence
    add_item(8'he2, 1, 1, 0);
    add_item(8'h82, 1, 0, 0);
    add_item(8'h78, 1, 1, 0);
    // close quote on a partial sequence drops it
    add_item(8'hf0, 1, 0, 0);
    add_item(8'h9f, 1, 0, 1);
    add_item(8'hff, 0, 1, 0);
    add_item(8'h00, 0, 0, 1);
  endfunction

  function automatic void pick_point(output logic [20:0] p, output int nb);
    logic [20:0] specials[8] = '{jse_pkg::PT_QUOTE, jse_pkg::PT_BSLASH, jse_pkg::PT_BS,
                                 jse_pkg::PT_FF, jse_pkg::PT_LF, jse_pkg::PT_CR,
                                 jse_pkg::PT_TAB, 21'h0};
    int k;
    k = $urandom_range(0, 9);
    nb = 1;
    if (k < 3) begin
      p = specials[$urandom_range(0, 7)];
    end else if (k < 5) begin
      p = 21'($urandom_range(0, 127));
    end else if (k == 5) begin
      p = 21'($urandom_range(21'h80, 21'h7ff));
      nb = 2;
    end else if (k == 6) begin
      p = 21'($urandom_range(21'h800, 21'hffff));
      nb = 3;
    end else if (k == 7) begin
      p = 21'($urandom_range(21'h10000, 21'h10ffff));
      nb = 4;
    end else if (k == 8) begin
      p = 21'($urandom_range(0, 127));
      nb = $urandom_range(2, 3);
    end else begin
      p = 21'($urandom_range(0, 21'h1fffff));
      nb = 4;
    end
  endfunction

  function automatic void add_random(int target);
    int          stop_at;
    int          len;
    int          r;
    int          nb;
    logic [20:0] p;
    stop_at = live_items + target;
    while (live_items < stop_at) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        len = $urandom_range(0, 6);
        if (len == 0) add_item(8'($urandom_range(0, 255)), 0, 1, 1);
        for (int i = 0; i < len; i++) begin
          pick_point(p, nb);
          add_point(p, nb, nb, i == 0, i == len - 1);
          if ($urandom_range(0, 15) == 0) add_item(8'($urandom_range(0, 255)), 0, 0, 0);
        end
      end else if (r == 7) begin
        nb = $urandom_range(2, 4);
        add_point(21'($urandom_range(0, 21'h1fffff)), nb, $urandom_range(1, nb - 1), 1,
                  $urandom_range(0, 1));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          add_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0,
                   $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
        end
      end
    end
  endfunction

  task automatic send_stim();
    str_item_t it;
    int        burst;
    int        gap;
    burst = $urandom_range(1, 24);
    while (stim.size() > 0) begin
      it = stim.pop_front();
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= it.data;
      s_axis_tuser <= {it.cq, it.oq, it.valid};
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
      sb.note_input(it.data, it.valid, it.oq, it.cq);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic write_mode(bit v);
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_mode(v);
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tlast);
    end
  end

  // receiver stall pattern
  initial begin
    int mode;
    int len;
    int phase;
    phase = 0;
    wait (!rst);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 0;
        @(posedge clk);
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      mode = $urandom_range(0, 2);
      len = $urandom_range(1, 40);
      repeat (len) begin
        @(posedge clk);
        phase++;
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= (phase % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    add_directed();
    send_stim();
    write_mode(1);
    add_directed();
    send_stim();
    for (int ph = 0; ph < 4; ph++) begin
      write_mode(ph % 2 == 0);
      if (ph == 0) long_hold_req = 1;
      add_random(25);
      send_stim();
    end
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("json_string_escaper_tb: PASS");
    end else begin
      $display("json_string_escaper_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #1200000;
    $display("%0t: timeout, %0d beats still expected", $time, sb.expected.size());
    $display("json_string_escaper_tb: FAIL");
    $finish;
  end

endmodule
